[sv/vnc_pkg.sv]
// Package for the vector length normalize / clamp unit.
// Holds beat structs, sideband structs, register indexes and pipeline depths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vnc_pkg;

  // fixed-point fraction bits and the unit length in that format
  localparam int unsigned FRAC_BITS = 16;
  localparam logic [31:0] UNIT_LEN  = 32'd1 << FRAC_BITS;

  // one stage per result bit in the square root and the dividers
  localparam int unsigned ISQ_STAGES = 32;
  localparam int unsigned DIV_STAGES = 32;

  // register reset values
  localparam logic [31:0] MAX_LEN_RST = 32'd65536;
  localparam logic [15:0] ZERO_THR_RST = 16'd66;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_MAX_LEN  = 2'd1,
    REG_ZERO_THR = 2'd2
  } reg_idx_t;

  // input beat
  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        length_in;
    logic               was_scaled;
    logic               was_zero;
  } out_t;

  // sideband carried alongside the square root
  typedef struct packed {
    in_t              raw;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [63:0]      sumsq;
    logic [63:0]      mx2;
  } sb_root_t;

  // sideband carried alongside the dividers
  typedef struct packed {
    in_t         raw;
    logic [2:0]  neg;
    logic [31:0] len;
    logic        zero;
    logic        scl;
  } sb_div_t;

endpackage

`default_nettype wire

[sv/vnc_isqrt.sv]
// Pipelined integer square root, one result bit per stage, rounded down.
// Depends on vnc_pkg for the stage count.
`timescale 1ns / 1ps
`default_nettype none

module vnc_isqrt
  import vnc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] rad,
  output logic      [31:0] root
);

  logic [35:0] rem_r  [ISQ_STAGES];
  logic [31:0] root_r [ISQ_STAGES];
  logic [63:0] rad_r  [ISQ_STAGES];

  for (genvar i = 0; i < ISQ_STAGES; i++) begin : g_st
    logic [35:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_in[33:0], rad_in[63:62]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[i]  <= rem_sh - trial;
          root_r[i] <= {root_in[30:0], 1'b1};
        end else begin
          rem_r[i]  <= rem_sh;
          root_r[i] <= {root_in[30:0], 1'b0};
        end
        rad_r[i] <= {rad_in[61:0], 2'b00};
      end
    end
  end

  assign root = root_r[ISQ_STAGES-1];

endmodule

`default_nettype wire

[sv/vnc_div.sv]
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor,
// one quotient bit per stage. Depends on vnc_pkg for the stage count.
`timescale 1ns / 1ps
`default_nettype none

module vnc_div
  import vnc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic      [31:0] quotient
);

  logic [31:0] rem_r [DIV_STAGES];
  logic [31:0] lo_r  [DIV_STAGES];
  logic [31:0] d_r   [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_st
    logic [31:0] rem_in;
    logic [31:0] lo_in;
    logic [31:0] d_in;
    logic [32:0] part;
    logic [32:0] diff;

    if (i == 0) begin : g_first
      assign rem_in = dividend[63:32];
      assign lo_in  = dividend[31:0];
      assign d_in   = divisor;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign lo_in  = lo_r[i-1];
      assign d_in   = d_r[i-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign part = {rem_in, lo_in[31]};
    assign diff = part - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        if (part >= {1'b0, d_in}) begin
          rem_r[i] <= diff[31:0];
          lo_r[i]  <= {lo_in[30:0], 1'b1};
        end else begin
          rem_r[i] <= part[31:0];
          lo_r[i]  <= {lo_in[30:0], 1'b0};
        end
        d_r[i] <= d_in;
      end
    end
  end

  assign quotient = lo_r[DIV_STAGES-1];

endmodule

`default_nettype wire

[sv/vector3_normalize_or_clamp_length_top.sv]
// Pipeline from input beat to result beat: 3 front stages, 32 root stages,
// 2 scale stages, 32 divider stages and an output register.
// Throughput: one beat per cycle; the whole pipeline holds when the output
// register is full and not taken.
// Reset: synchronous, active low; clears valid bits and loads mode 0,
// max_length 65536, zero_threshold 66.
`timescale 1ns / 1ps
`default_nettype none

module vector3_normalize_or_clamp_length_top
  import vnc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  // saturate a sign and magnitude into 32-bit two's complement
  function automatic logic [31:0] pack_sat(input logic neg, input logic [31:0] q);
    logic [31:0] m;
    if (neg) begin
      m = (q > 32'h8000_0000) ? 32'h8000_0000 : q;
      pack_sat = 32'd0 - m;
    end else begin
      pack_sat = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
    end
  endfunction

  // configuration registers
  logic        mode_r;
  logic [31:0] max_len_r;
  logic [15:0] zero_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      max_len_r  <= MAX_LEN_RST;
      zero_thr_r <= ZERO_THR_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_MODE:     mode_r     <= cfg_wdata[0];
        REG_MAX_LEN:  max_len_r  <= cfg_wdata;
        REG_ZERO_THR: zero_thr_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // global advance: hold everything while the output beat waits
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage 1: magnitudes and signs
  logic [31:0]      in_c [3];
  logic             s1_v_r;
  in_t              s1_raw_r;
  logic [2:0][31:0] s1_mag_r;
  logic [2:0]       s1_neg_r;

  assign in_c[0] = in_data.in_x;
  assign in_c[1] = in_data.in_y;
  assign in_c[2] = in_data.in_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_raw_r <= in_data;
      for (int k = 0; k < 3; k++) begin
        s1_mag_r[k] <= in_c[k][31] ? (32'd0 - in_c[k]) : in_c[k];
        s1_neg_r[k] <= in_c[k][31];
      end
    end
  end

  // stage 2: squares and squared limit
  logic [63:0]      sq_nxt [3];
  logic [63:0]      mx2_nxt;
  logic             s2_v_r;
  in_t              s2_raw_r;
  logic [2:0][31:0] s2_mag_r;
  logic [2:0]       s2_neg_r;
  logic [63:0]      s2_sq_r [3];
  logic [63:0]      s2_mx2_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = s1_mag_r[k] * s1_mag_r[k];
    end
    mx2_nxt = max_len_r * max_len_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_raw_r <= s1_raw_r;
      s2_mag_r <= s1_mag_r;
      s2_neg_r <= s1_neg_r;
      s2_mx2_r <= mx2_nxt;
      for (int k = 0; k < 3; k++) begin
        s2_sq_r[k] <= sq_nxt[k];
      end
    end
  end

  // stage 3: sum of squares
  logic     s3_v_r;
  sb_root_t s3_sb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sb_r.raw   <= s2_raw_r;
      s3_sb_r.mag   <= s2_mag_r;
      s3_sb_r.neg   <= s2_neg_r;
      s3_sb_r.mx2   <= s2_mx2_r;
      s3_sb_r.sumsq <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
    end
  end

  // square root, sideband travels in step
  logic [31:0] root;
  logic        isq_v_r  [ISQ_STAGES];
  sb_root_t    isq_sb_r [ISQ_STAGES];

  vnc_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (s3_sb_r.sumsq),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      isq_sb_r[0] <= s3_sb_r;
      for (int i = 1; i < ISQ_STAGES; i++) begin
        isq_sb_r[i] <= isq_sb_r[i-1];
      end
    end
  end

  // stage 4: flags and component times target
  sb_root_t    sb_a;
  logic [31:0] target;
  logic [63:0] prod_nxt [3];
  logic        s4_v_r;
  sb_div_t     s4_sb_r;
  logic [63:0] s4_prod_r [3];

  assign sb_a   = isq_sb_r[ISQ_STAGES-1];
  assign target = mode_r ? UNIT_LEN : max_len_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = sb_a.mag[k] * target;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sb_r.raw  <= sb_a.raw;
      s4_sb_r.neg  <= sb_a.neg;
      s4_sb_r.len  <= root;
      s4_sb_r.zero <= (root <= {16'd0, zero_thr_r});
      s4_sb_r.scl  <= mode_r || (sb_a.sumsq > sb_a.mx2);
      for (int k = 0; k < 3; k++) begin
        s4_prod_r[k] <= prod_nxt[k];
      end
    end
  end

  // stage 5: add half the divisor for round to nearest
  logic        s5_v_r;
  sb_div_t     s5_sb_r;
  logic [63:0] s5_dvd_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_sb_r <= s4_sb_r;
      for (int k = 0; k < 3; k++) begin
        s5_dvd_r[k] <= s4_prod_r[k] + {33'd0, s4_sb_r.len[31:1]};
      end
    end
  end

  // three dividers, sideband travels in step
  logic [31:0] quo [3];
  logic        div_v_r  [DIV_STAGES];
  sb_div_t     div_sb_r [DIV_STAGES];

  for (genvar k = 0; k < 3; k++) begin : g_div
    vnc_div u_div (
      .clk      (clk),
      .en       (adv),
      .dividend (s5_dvd_r[k]),
      .divisor  (s5_sb_r.len),
      .quotient (quo[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_sb_r[0] <= s5_sb_r;
      for (int i = 1; i < DIV_STAGES; i++) begin
        div_sb_r[i] <= div_sb_r[i-1];
      end
    end
  end

  // output register: select zero, scaled or pass-through
  sb_div_t sb_b;
  out_t    out_nxt;
  out_t    out_r;

  assign sb_b = div_sb_r[DIV_STAGES-1];

  always_comb begin
    out_nxt.length_in = sb_b.len;
    out_nxt.was_zero  = sb_b.zero;
    if (sb_b.zero) begin
      out_nxt.out_x      = '0;
      out_nxt.out_y      = '0;
      out_nxt.out_z      = '0;
      out_nxt.was_scaled = 1'b0;
    end else if (sb_b.scl) begin
      out_nxt.out_x      = pack_sat(sb_b.neg[0], quo[0]);
      out_nxt.out_y      = pack_sat(sb_b.neg[1], quo[1]);
      out_nxt.out_z      = pack_sat(sb_b.neg[2], quo[2]);
      out_nxt.was_scaled = 1'b1;
    end else begin
      out_nxt.out_x      = sb_b.raw.in_x;
      out_nxt.out_y      = sb_b.raw.in_y;
      out_nxt.out_z      = sb_b.raw.in_z;
      out_nxt.was_scaled = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  // valid bits, advanced with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ISQ_STAGES; i++) isq_v_r[i] <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) div_v_r[i] <= 1'b0;
    end else if (adv) begin
      s1_v_r     <= in_valid;
      s2_v_r     <= s1_v_r;
      s3_v_r     <= s2_v_r;
      isq_v_r[0] <= s3_v_r;
      for (int i = 1; i < ISQ_STAGES; i++) isq_v_r[i] <= isq_v_r[i-1];
      s4_v_r     <= isq_v_r[ISQ_STAGES-1];
      s5_v_r     <= s4_v_r;
      div_v_r[0] <= s5_v_r;
      for (int i = 1; i < DIV_STAGES; i++) div_v_r[i] <= div_v_r[i-1];
      out_valid_r <= div_v_r[DIV_STAGES-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a zero beat carries zero components and no scaling
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.was_zero) |->
      (out_r.out_x == '0 && out_r.out_y == '0 && out_r.out_z == '0 && !out_r.was_scaled))
    else $error("zero beat with nonzero result");

  // a beat not counted as zero has a length above the threshold
  a_thr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.was_zero) |-> (out_r.length_in > {16'd0, zero_thr_r}))
    else $error("zero flag disagrees with threshold");

  // normalize mode scales every beat that is not zero
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mode_r && !out_r.was_zero) |-> out_r.was_scaled)
    else $error("normalize beat not scaled");

  // a held output stage freezes the front of the pipeline too
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(s1_v_r) && $stable(out_r)))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
